@@ rtl/wsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, constants, codes and helpers for the wheel sync controller.
// ----------------------------------------------------------------------------
package wsp_pkg;

	// encoder count width and derived error width
	localparam int COUNT_BITS     = 32;
	localparam int ERR_BITS       = COUNT_BITS + 2;

	// gain fixed point
	localparam int GAIN_FRAC_BITS = 16;
	localparam int GAIN_BITS      = 16;

	// drive command limits
	localparam int DRIVE_BITS     = 8;
	localparam int DRIVE_MAX      = 100;

	// error magnitude clamp before the gain multiply; 2^8 times the smallest
	// nonzero gain already drives any speed past the saturation limit
	localparam int ECLAMP_BITS    = GAIN_FRAC_BITS + 8;
	localparam int ECLAMP_W       = ECLAMP_BITS + 1;
	localparam logic signed [ERR_BITS-1:0] ECLAMP_POS =
		ERR_BITS'((64'd1 << ECLAMP_BITS) - 64'd1);
	localparam logic signed [ERR_BITS-1:0] ECLAMP_NEG = -ECLAMP_POS;

	// gain product and running sum
	localparam int PROD_W         = GAIN_BITS + 1 + ECLAMP_W;
	localparam int TOTAL_W        = PROD_W + 1;
	localparam int QUOT_W         = TOTAL_W - GAIN_FRAC_BITS;

	// divide by 50 through a reciprocal: q = (n * RECIP_50) >> RECIP_SHIFT,
	// exact for every n up to 2^31
	localparam int RECIP_SHIFT    = 37;
	localparam logic [31:0] RECIP_50 = 32'd2748779070;
	localparam int QDIV_W         = 26;

	// elapsed time
	localparam int ELAPSED_BITS   = 32;

	// config register widths
	localparam int LIMIT_BITS     = 31;
	localparam int CYCLE_BITS     = 10;
	localparam int CFG_DATA_BITS  = 31;
	localparam int CFG_IDX_BITS   = 3;

	// config register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_LEFT_SPEED  = 3'd0,
		CFG_RIGHT_SPEED = 3'd1,
		CFG_LIMIT_MODE  = 3'd2,
		CFG_STOP_LIMIT  = 3'd3,
		CFG_GAIN        = 3'd4,
		CFG_CYCLE_MS    = 3'd5
	} cfg_idx_t;

	// item codes
	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// limit modes
	localparam logic MODE_TICKS   = 1'b0;
	localparam logic MODE_ELAPSED = 1'b1;

	// reset values
	localparam logic signed [DRIVE_BITS-1:0] RST_LEFT_SPEED  = 8'sd70;
	localparam logic signed [DRIVE_BITS-1:0] RST_RIGHT_SPEED = 8'sd70;
	localparam logic                         RST_LIMIT_MODE  = MODE_ELAPSED;
	localparam logic [LIMIT_BITS-1:0]        RST_STOP_LIMIT  = 31'd5000;
	localparam logic [GAIN_BITS-1:0]         RST_GAIN        = 16'd19661;
	localparam logic [CYCLE_BITS-1:0]        RST_CYCLE_MS    = 10'd50;

	// clamp a wide signed value to +-DRIVE_MAX
	function automatic logic signed [DRIVE_BITS-1:0] sat_drive(
		input logic signed [QUOT_W-1:0] x
	);
		logic signed [DRIVE_BITS-1:0] r;
		if (x > QUOT_W'(DRIVE_MAX))
			r = DRIVE_BITS'(DRIVE_MAX);
		else if (x < -QUOT_W'(DRIVE_MAX))
			r = -DRIVE_BITS'(DRIVE_MAX);
		else
			r = x[DRIVE_BITS-1:0];
		return r;
	endfunction

endpackage

@@ rtl/wheel_sync_p_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_sync_p_controller
// Proportional speed sync for a two-wheel drive: corrects the left encoder
// count, forms tick deltas from latched baselines, and scales the error into
// a saturated right drive command, with a stop flag on ticks or time.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+--------------------
//  input   | in_valid in_ready op left_count right_count | in_valid & in_ready
//  output  | out_valid out_ready left_drive right_drive  | out_valid & out_ready
//          | running sync_error                         |
//  config  | cfg_valid cfg_ready cfg_index cfg_data     | cfg_valid & cfg_ready
//
//  Five register stages: input, divide-by-50 product, error and state update,
//  gain product, result. One item per cycle sustained while out_ready is high.
//  Each stage loads whenever it is empty or moving on, so bubbles absorb an
//  output stall before in_ready drops. Reset restores the config defaults and
//  clears the baselines and elapsed time; cfg_ready is always high.
// ----------------------------------------------------------------------------
module wheel_sync_p_controller (
	input  logic                                          clk,
	input  logic                                          arst_n,
	// input channel
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic                                          op,
	input  logic signed [31:0]                            left_count,
	input  logic signed [31:0]                            right_count,
	// output channel
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic signed [wsp_pkg::DRIVE_BITS-1:0]         left_drive,
	output logic signed [wsp_pkg::DRIVE_BITS-1:0]         right_drive,
	output logic                                          running,
	output logic signed [wsp_pkg::ERR_BITS-1:0]           sync_error,
	// config channel
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [wsp_pkg::CFG_IDX_BITS-1:0]              cfg_index,
	input  logic [wsp_pkg::CFG_DATA_BITS-1:0]             cfg_data
);

	localparam int CB = wsp_pkg::COUNT_BITS;
	localparam int EB = wsp_pkg::ERR_BITS;
	localparam int FB = wsp_pkg::GAIN_FRAC_BITS;

	// config registers
	logic signed [wsp_pkg::DRIVE_BITS-1:0] left_speed_q;
	logic signed [wsp_pkg::DRIVE_BITS-1:0] right_speed_q;
	logic                                  limit_mode_q;
	logic [wsp_pkg::LIMIT_BITS-1:0]        stop_limit_q;
	logic [wsp_pkg::GAIN_BITS-1:0]         gain_q;
	logic [wsp_pkg::CYCLE_BITS-1:0]        cycle_ms_q;

	// state
	logic signed [CB-1:0]                  left_base_q;
	logic signed [CB-1:0]                  right_base_q;
	logic [wsp_pkg::ELAPSED_BITS-1:0]      elapsed_q;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;

	// stage payloads
	logic                                  op_s1, op_s2;
	logic signed [31:0]                    lc_s1, lc_s2, rc_s1, rc_s2;
	logic                                  lneg_s2;
	logic [wsp_pkg::QDIV_W-1:0]            q_s2;
	logic signed [EB-1:0]                  err_s3, err_s4;
	logic                                  run_s3, run_s4;
	logic signed [wsp_pkg::TOTAL_W-1:0]    total_s4;

	// ready chain: a stage loads when empty or when its contents move on
	assign rdy_out  = !out_valid || out_ready;
	assign rdy_s4   = !v_s4 || rdy_out;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign cfg_ready = 1'b1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_speed_q  <= wsp_pkg::RST_LEFT_SPEED;
			right_speed_q <= wsp_pkg::RST_RIGHT_SPEED;
			limit_mode_q  <= wsp_pkg::RST_LIMIT_MODE;
			stop_limit_q  <= wsp_pkg::RST_STOP_LIMIT;
			gain_q        <= wsp_pkg::RST_GAIN;
			cycle_ms_q    <= wsp_pkg::RST_CYCLE_MS;
		end else if (cfg_valid && cfg_ready) begin
			case (wsp_pkg::cfg_idx_t'(cfg_index))
				wsp_pkg::CFG_LEFT_SPEED:  left_speed_q  <= cfg_data[wsp_pkg::DRIVE_BITS-1:0];
				wsp_pkg::CFG_RIGHT_SPEED: right_speed_q <= cfg_data[wsp_pkg::DRIVE_BITS-1:0];
				wsp_pkg::CFG_LIMIT_MODE:  limit_mode_q  <= cfg_data[0];
				wsp_pkg::CFG_STOP_LIMIT:  stop_limit_q  <= cfg_data[wsp_pkg::LIMIT_BITS-1:0];
				wsp_pkg::CFG_GAIN:        gain_q        <= cfg_data[wsp_pkg::GAIN_BITS-1:0];
				wsp_pkg::CFG_CYCLE_MS:    cycle_ms_q    <= cfg_data[wsp_pkg::CYCLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1      <= in_valid;
			if (rdy_s2)  v_s2      <= v_s1;
			if (rdy_s3)  v_s3      <= v_s2;
			if (rdy_s4)  v_s4      <= v_s3;
			if (rdy_out) out_valid <= v_s4;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			op_s1 <= op;
			lc_s1 <= left_count;
			rc_s1 <= right_count;
		end
	end

	// stage 2: |left| / 50 by reciprocal multiply
	logic [31:0] labs;
	logic [63:0] div_prod;
	assign labs     = lc_s1[31] ? 32'(-lc_s1) : 32'(lc_s1);
	assign div_prod = 64'(labs) * 64'(wsp_pkg::RECIP_50);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			op_s2   <= op_s1;
			lc_s2   <= lc_s1;
			rc_s2   <= rc_s1;
			lneg_s2 <= lc_s1[31];
			q_s2    <= div_prod[wsp_pkg::RECIP_SHIFT +: wsp_pkg::QDIV_W];
		end
	end

	// stage 3: corrected count, deltas, error, running flag, state update
	logic signed [CB-1:0] qs;
	logic signed [CB-1:0] lcorr, rcorr, dl, dr;
	logic signed [EB-1:0] dl_x, dr_x, err_c;
	logic [wsp_pkg::ELAPSED_BITS:0] t_sum;
	logic [wsp_pkg::ELAPSED_BITS-1:0] elapsed_d;
	logic [31:0] rabs;
	logic run_c;
	logic adv_s2;

	assign adv_s2 = v_s2 && rdy_s3;
	assign qs     = lneg_s2 ? -CB'(q_s2) : CB'(q_s2);
	assign lcorr  = CB'(lc_s2) + qs;
	assign rcorr  = CB'(rc_s2);
	assign dl     = lcorr - left_base_q;
	assign dr     = rcorr - right_base_q;
	assign dl_x   = EB'(dl);
	assign dr_x   = EB'(dr);
	assign t_sum  = {1'b0, elapsed_q} + (wsp_pkg::ELAPSED_BITS + 1)'(cycle_ms_q);
	assign rabs   = rc_s2[31] ? 32'(-rc_s2) : 32'(rc_s2);

	always_comb begin
		err_c     = '0;
		elapsed_d = '0;
		if (op_s2 == wsp_pkg::OP_SAMPLE) begin
			if (dl > 0 && dr > 0)
				err_c = dl_x - dr_x;
			else
				err_c = -(dl_x + dr_x);
			elapsed_d = t_sum[wsp_pkg::ELAPSED_BITS] ? '1 : t_sum[wsp_pkg::ELAPSED_BITS-1:0];
		end
		if (limit_mode_q == wsp_pkg::MODE_ELAPSED)
			run_c = elapsed_d < wsp_pkg::ELAPSED_BITS'(stop_limit_q);
		else
			run_c = {1'b0, rabs} < 33'(stop_limit_q);
	end

	// baselines and elapsed time follow each item as it leaves stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_base_q  <= '0;
			right_base_q <= '0;
			elapsed_q    <= '0;
		end else if (adv_s2) begin
			elapsed_q <= elapsed_d;
			if (op_s2 == wsp_pkg::OP_START) begin
				left_base_q  <= lcorr;
				right_base_q <= rcorr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			err_s3 <= err_c;
			run_s3 <= run_c;
		end
	end

	// stage 4: clamp error, gain multiply, add base speed
	logic signed [EB-1:0]                 err_cl;
	logic signed [wsp_pkg::ECLAMP_W-1:0]  err_n;
	logic signed [wsp_pkg::PROD_W-1:0]    gprod;
	logic signed [wsp_pkg::TOTAL_W-1:0]   total_c;

	always_comb begin
		if (err_s3 > wsp_pkg::ECLAMP_POS)
			err_cl = wsp_pkg::ECLAMP_POS;
		else if (err_s3 < wsp_pkg::ECLAMP_NEG)
			err_cl = wsp_pkg::ECLAMP_NEG;
		else
			err_cl = err_s3;
	end

	assign err_n   = err_cl[wsp_pkg::ECLAMP_W-1:0];
	assign gprod   = $signed({1'b0, gain_q}) * err_n;
	assign total_c = (wsp_pkg::TOTAL_W'(right_speed_q) <<< FB) + wsp_pkg::TOTAL_W'(gprod);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			err_s4   <= err_s3;
			run_s4   <= run_s3;
			total_s4 <= total_c;
		end
	end

	// result: divide by 2^F truncating toward zero, saturate
	logic signed [wsp_pkg::QUOT_W-1:0] quot_fl, quot;
	logic frac_nz;
	assign quot_fl = total_s4[wsp_pkg::TOTAL_W-1:FB];
	assign frac_nz = |total_s4[FB-1:0];
	assign quot    = (total_s4[wsp_pkg::TOTAL_W-1] && frac_nz) ? quot_fl + 1'b1 : quot_fl;

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			left_drive  <= wsp_pkg::sat_drive(wsp_pkg::QUOT_W'(left_speed_q));
			right_drive <= wsp_pkg::sat_drive(quot);
			running     <= run_s4;
			sync_error  <= err_s4;
		end
	end

endmodule

@@ bench/drive_cmd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_cmd_checker
// Watches the input, config and output channels of the wheel sync controller.
// Keeps its own copy of the registers, baselines and elapsed time, predicts
// the drive command for every accepted item and compares each output
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module drive_cmd_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic                                  op,
	input  logic signed [31:0]                    left_count,
	input  logic signed [31:0]                    right_count,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [wsp_pkg::DRIVE_BITS-1:0] left_drive,
	input  logic signed [wsp_pkg::DRIVE_BITS-1:0] right_drive,
	input  logic                                  running,
	input  logic signed [wsp_pkg::ERR_BITS-1:0]   sync_error,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [wsp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [wsp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output int                                    fail_count,
	output int                                    pending
);

	localparam int DB = wsp_pkg::DRIVE_BITS;
	localparam int EB = wsp_pkg::ERR_BITS;
	localparam int CB = wsp_pkg::COUNT_BITS;

	typedef struct {
		logic signed [DB-1:0] l_cmd;
		logic signed [DB-1:0] r_cmd;
		logic                 run;
		logic signed [EB-1:0] err;
	} drive_cmd_t;

	localparam longint ELAPSED_TOP = (longint'(1) <<< wsp_pkg::ELAPSED_BITS) - 1;
	localparam longint ERR_LIMIT   = longint'(1) <<< 40;
	localparam longint GAIN_ONE    = longint'(1) <<< wsp_pkg::GAIN_FRAC_BITS;
	localparam longint DRIVE_TOP   = wsp_pkg::DRIVE_MAX;
	localparam int     MAX_REPORTS = 10;

	// register copy
	longint speed_l, speed_r, stop_at, gain_k, period_ms;
	logic   mode_sel;
	// baselines and time since start
	longint base_l, base_r, elapsed;
	int     bad;

	drive_cmd_t expected_cmds[$];

	// sign-extend from the encoder count width
	function automatic longint wrap_ticks(input longint x);
		return (x <<< (64 - CB)) >>> (64 - CB);
	endfunction

	function automatic longint clamp_drive(input longint x);
		if (x > DRIVE_TOP)
			return DRIVE_TOP;
		if (x < -DRIVE_TOP)
			return -DRIVE_TOP;
		return x;
	endfunction

	// next drive command; updates baselines and elapsed time
	function automatic drive_cmd_t predict_drive(
		input logic               kind,
		input logic signed [31:0] l_raw,
		input logic signed [31:0] r_raw
	);
		longint lw, rw, l_fix, r_fix, dl, dr, err, e, total, r_cmd, r_mag;
		drive_cmd_t c;
		lw = l_raw;
		rw = r_raw;
		// left encoder runs slow by one part in fifty
		l_fix = wrap_ticks(lw + lw / 50);
		r_fix = wrap_ticks(rw);
		err = 0;
		if (kind == wsp_pkg::OP_START) begin
			base_l = l_fix;
			base_r = r_fix;
			elapsed = 0;
			r_cmd = clamp_drive(speed_r);
		end else begin
			dl = wrap_ticks(l_fix - base_l);
			dr = wrap_ticks(r_fix - base_r);
			// straight when both wheels went forward, otherwise turning
			if (dl > 0 && dr > 0)
				err = dl - dr;
			else
				err = -(dl + dr);
			elapsed = elapsed + period_ms;
			if (elapsed > ELAPSED_TOP)
				elapsed = ELAPSED_TOP;
			e = err;
			if (e > ERR_LIMIT)
				e = ERR_LIMIT;
			if (e < -ERR_LIMIT)
				e = -ERR_LIMIT;
			total = speed_r * GAIN_ONE + gain_k * e;
			r_cmd = clamp_drive(total / GAIN_ONE);
		end
		r_mag = (rw < 0) ? -rw : rw;
		c.run = (mode_sel == wsp_pkg::MODE_ELAPSED) ? (elapsed < stop_at) : (r_mag < stop_at);
		c.l_cmd = DB'(clamp_drive(speed_l));
		c.r_cmd = DB'(r_cmd);
		c.err = EB'(err);
		return c;
	endfunction

	// track config, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		drive_cmd_t want;
		if (!arst_n) begin
			speed_l = wsp_pkg::RST_LEFT_SPEED;
			speed_r = wsp_pkg::RST_RIGHT_SPEED;
			mode_sel = wsp_pkg::RST_LIMIT_MODE;
			stop_at = wsp_pkg::RST_STOP_LIMIT;
			gain_k = wsp_pkg::RST_GAIN;
			period_ms = wsp_pkg::RST_CYCLE_MS;
			base_l = 0;
			base_r = 0;
			elapsed = 0;
			bad = 0;
			expected_cmds.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					wsp_pkg::CFG_LEFT_SPEED:
						speed_l = longint'(signed'(cfg_data[DB-1:0]));
					wsp_pkg::CFG_RIGHT_SPEED:
						speed_r = longint'(signed'(cfg_data[DB-1:0]));
					wsp_pkg::CFG_LIMIT_MODE:
						mode_sel = cfg_data[0];
					wsp_pkg::CFG_STOP_LIMIT:
						stop_at = longint'(cfg_data[wsp_pkg::LIMIT_BITS-1:0]);
					wsp_pkg::CFG_GAIN:
						gain_k = longint'(cfg_data[wsp_pkg::GAIN_BITS-1:0]);
					wsp_pkg::CFG_CYCLE_MS:
						period_ms = longint'(cfg_data[wsp_pkg::CYCLE_BITS-1:0]);
					default: ;
				endcase
			end
			// output transfer
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					if (bad < MAX_REPORTS)
						$display("unexpected result: L=%0d R=%0d run=%0b err=%0d",
							left_drive, right_drive, running, sync_error);
					bad++;
				end else begin
					want = expected_cmds.pop_front();
					if (want.l_cmd !== left_drive || want.r_cmd !== right_drive ||
						want.run !== running || want.err !== sync_error) begin
						if (bad < MAX_REPORTS)
							$display({"mismatch: exp L=%0d R=%0d run=%0b err=%0d,",
								" got L=%0d R=%0d run=%0b err=%0d"},
								want.l_cmd, want.r_cmd, want.run, want.err,
								left_drive, right_drive, running, sync_error);
						bad++;
					end
				end
			end
			// input transfer
			if (in_valid && in_ready)
				expected_cmds.push_back(predict_drive(op, left_count, right_count));
			fail_count <= bad;
			pending <= expected_cmds.size();
		end
	end

endmodule

@@ bench/wheel_sync_p_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_sync_p_controller_tb
// Drives the wheel sync controller through several register settings with a
// short directed run and then start/sample sequences mixed with raw noise,
// with random gaps on both channels. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module wheel_sync_p_controller_tb;

	localparam logic signed [31:0] MIN_COUNT = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_COUNT = 32'sh7FFF_FFFF;
	localparam int unsigned        MAX_LIMIT = 32'h7FFF_FFFF;
	localparam int                 DB        = wsp_pkg::DRIVE_BITS;
	localparam int                 EB        = wsp_pkg::ERR_BITS;
	localparam int                 IB        = wsp_pkg::CFG_IDX_BITS;
	localparam int                 WB        = wsp_pkg::CFG_DATA_BITS;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          op;
	logic signed [31:0]            left_count;
	logic signed [31:0]            right_count;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [DB-1:0]          left_drive;
	logic signed [DB-1:0]          right_drive;
	logic                          running;
	logic signed [EB-1:0]          sync_error;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [IB-1:0]                 cfg_index;
	logic [WB-1:0]                 cfg_data;
	int                            fail_count;
	int                            pending;

	bit                            tx_calm = 1'b0;
	bit                            rx_calm = 1'b0;
	int                            stall_left = 0;

	wheel_sync_p_controller DUT (.*);

	drive_cmd_checker checker_i (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// output side backpressure
	always @(negedge clk) begin
		if (rx_calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 65) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			stall_left <= idle_len();
		end
	end

	// one input transfer, with a random gap ahead of it
	task automatic push_item(
		input logic               kind,
		input logic signed [31:0] l,
		input logic signed [31:0] r
	);
		int gap;
		gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		left_count <= l;
		right_count <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// hold the sender until every prediction is matched
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input wsp_pkg::cfg_idx_t idx, input logic [WB-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_regs(
		input int          ls,
		input int          rs,
		input logic        mode,
		input int unsigned lim,
		input int          gain,
		input int          cyc
	);
		drain();
		write_reg(wsp_pkg::CFG_LEFT_SPEED, WB'(ls));
		write_reg(wsp_pkg::CFG_RIGHT_SPEED, WB'(rs));
		write_reg(wsp_pkg::CFG_LIMIT_MODE, WB'(mode));
		write_reg(wsp_pkg::CFG_STOP_LIMIT, WB'(lim));
		write_reg(wsp_pkg::CFG_GAIN, WB'(gain));
		write_reg(wsp_pkg::CFG_CYCLE_MS, WB'(cyc));
	endtask

	// start/sample runs with random motion, plus raw noise items
	task automatic drive_runs(input int count);
		int sent, len, k, lstep, rstep;
		logic signed [31:0] lc, rc;
		sent = 0;
		while (sent < count) begin
			tx_calm = ($urandom_range(0, 5) == 0);
			rx_calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 99) < 15) begin
				push_item($urandom_range(0, 1) ? wsp_pkg::OP_SAMPLE : wsp_pkg::OP_START,
					$urandom, $urandom);
				sent++;
			end else begin
				case ($urandom_range(0, 3))
					0, 1: begin
						lc = $urandom_range(0, 4000) - 2000;
						rc = $urandom_range(0, 4000) - 2000;
					end
					2: begin
						lc = $urandom;
						rc = $urandom;
					end
					default: begin
						// near the wrap points of the counters
						lc = MAX_COUNT - $urandom_range(0, 255);
						rc = MIN_COUNT + $urandom_range(0, 255);
					end
				endcase
				push_item(wsp_pkg::OP_START, lc, rc);
				sent++;
				len = $urandom_range(2, 20);
				for (k = 0; k < len; k++) begin
					lstep = $urandom_range(0, 60);
					rstep = $urandom_range(0, 60);
					if ($urandom_range(0, 99) < 20)
						lstep = -lstep;
					if ($urandom_range(0, 99) < 20)
						rstep = -rstep;
					if ($urandom_range(0, 3) == 0)
						rstep = lstep;
					lc = lc + lstep;
					rc = rc + rstep;
					push_item(wsp_pkg::OP_SAMPLE, lc, rc);
					sent++;
				end
			end
			if ($urandom_range(0, 49) == 0)
				drain();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// stimulus
	initial begin
		int ph;
		logic mode;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = wsp_pkg::OP_START;
		left_count = '0;
		right_count = '0;
		cfg_valid = 1'b0;
		cfg_index = wsp_pkg::CFG_LEFT_SPEED;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: samples before any start, then edge counts
		push_item(wsp_pkg::OP_SAMPLE, 1000, 900);
		push_item(wsp_pkg::OP_SAMPLE, -500, 300);
		push_item(wsp_pkg::OP_START, 0, 0);
		push_item(wsp_pkg::OP_SAMPLE, 100, 100);
		push_item(wsp_pkg::OP_SAMPLE, -49, 40);
		push_item(wsp_pkg::OP_SAMPLE, -51, -40);
		push_item(wsp_pkg::OP_SAMPLE, 0, 0);
		push_item(wsp_pkg::OP_START, MIN_COUNT, MAX_COUNT);
		push_item(wsp_pkg::OP_SAMPLE, MAX_COUNT, MIN_COUNT);
		push_item(wsp_pkg::OP_SAMPLE, MIN_COUNT, MAX_COUNT);
		push_item(wsp_pkg::OP_START, MAX_COUNT, MIN_COUNT);
		push_item(wsp_pkg::OP_SAMPLE, 0, 0);
		push_item(wsp_pkg::OP_START, 1000, 1000);
		push_item(wsp_pkg::OP_SAMPLE, 1500, 900);
		push_item(wsp_pkg::OP_SAMPLE, 900, 1500);

		// out-of-range speeds, tick mode at zero, full gain, longest period
		load_regs(127, -128, wsp_pkg::MODE_TICKS, 0, 65535, 1023);
		push_item(wsp_pkg::OP_START, MIN_COUNT, MIN_COUNT);
		push_item(wsp_pkg::OP_SAMPLE, MAX_COUNT, MAX_COUNT);
		push_item(wsp_pkg::OP_SAMPLE, 0, MIN_COUNT);
		push_item(wsp_pkg::OP_SAMPLE, 5, 5);
		drive_runs(150);

		// no gain, largest limit, zero period
		load_regs(-100, 100, wsp_pkg::MODE_ELAPSED, MAX_LIMIT, 0, 0);
		drive_runs(100);

		load_regs(-128, 127, wsp_pkg::MODE_TICKS, MAX_LIMIT, 1, 1);
		drive_runs(100);

		// random settings that let the stop flag change within a run
		for (ph = 0; ph < 5; ph++) begin
			mode = $urandom_range(0, 1) ? wsp_pkg::MODE_ELAPSED : wsp_pkg::MODE_TICKS;
			load_regs($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100, mode,
				(mode == wsp_pkg::MODE_TICKS && $urandom_range(0, 3) == 0) ?
					($urandom >> 1) :
					$urandom_range(0, (mode == wsp_pkg::MODE_TICKS) ? 3000 : 1500),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 65535),
				($urandom_range(0, 4) == 0) ? $urandom_range(1, 1000) : $urandom_range(1, 100));
			drive_runs(140);
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ wheel_sync_p_controller.f @@
rtl/wsp_pkg.sv
rtl/wheel_sync_p_controller.sv
bench/drive_cmd_checker.sv
bench/wheel_sync_p_controller_tb.sv
